[rtl/afr_pkg.sv]
// shared types and constants for the acknowledge frame receiver
// no dependencies; imported by every afr module
package afr_pkg;

  // item kinds on the input channel (the fourth code is ignored)
  typedef enum logic [1:0] {
    MODE_ARM  = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_TICK = 2'd2
  } afr_mode_e;

  // result codes
  typedef enum logic [1:0] {
    ST_ACK     = 2'd0,
    ST_NACK    = 2'd1,
    ST_TIMEOUT = 2'd2
  } afr_status_e;

  // frame parser phases, one-hot
  typedef enum logic [5:0] {
    PH_SYNC1   = 6'b000001,
    PH_SYNC2   = 6'b000010,
    PH_LEN_HI  = 6'b000100,
    PH_LEN_LO  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_END     = 6'b100000
  } afr_phase_e;

  localparam logic [7:0]  SyncFirst    = 8'hA0;
  localparam logic [7:0]  SyncSecond   = 8'hA1;
  localparam logic [7:0]  EndByte      = 8'h0A;
  localparam logic [7:0]  AckId        = 8'h83;
  localparam logic [15:0] TimeoutReset = 16'd5000;
  localparam logic [15:0] TickMax      = 16'hFFFF;

  // input request payload
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } afr_in_t;

  // result payload
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] message_id;
  } afr_out_t;

endpackage

[rtl/ack_frame_receiver.sv]
// top level of the acknowledge frame receiver: input register, config, output
// depends on afr_pkg, afr_parser, afr_out_reg
//
// Takes one request per cycle while in_stall_o is low: arm, received byte or
// millisecond tick. Each request is held in the input register, where the
// parser updates its state and, for an end-of-frame byte or an expiring tick,
// forms a result that is loaded into the output register in the same cycle
// that the request leaves the input register. A request that produces a
// result waits in the input register only while the output register holds
// an undelivered result that is stalled. The timeout limit is written through
// the config channel, which is always ready; write it only while idle.
module ack_frame_receiver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  afr_pkg::afr_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output afr_pkg::afr_out_t out_item_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);
  import afr_pkg::*;

  logic        hold_valid_q;
  afr_in_t     hold_item_q;
  logic [15:0] timeout_q;
  logic        res_valid;
  afr_out_t    res;
  logic        room;
  logic        advance;
  logic        accept;

  assign cfg_ready_o = 1'b1;
  assign advance     = !res_valid || room;
  assign in_stall_o  = hold_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;

  // timeout limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (accept) begin
      hold_valid_q <= 1'b1;
    end else if (advance) begin
      hold_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (accept) hold_item_q <= in_item_i;
  end

  afr_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (hold_valid_q),
    .commit_i       (advance),
    .item_i         (hold_item_q),
    .timeout_ticks_i(timeout_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  afr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

[rtl/afr_parser.sv]
// frame parser and tick counter: holds the wait state and forms the result
// depends on afr_pkg
module afr_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic              commit_i,
  input  afr_pkg::afr_in_t  item_i,
  input  logic [15:0]       timeout_ticks_i,
  output logic              res_valid_o,
  output afr_pkg::afr_out_t res_o
);
  import afr_pkg::*;

  logic        armed_q, armed_d;
  afr_phase_e  phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [16:0] cnt_q, cnt_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] ela_q, ela_d;

  logic        is_arm, is_byte, is_tick;
  logic [16:0] cnt_inc;
  logic [15:0] ela_inc;
  logic [7:0]  b;

  assign b       = item_i.rx_byte;
  assign is_arm  = item_i.mode == MODE_ARM;
  assign is_byte = armed_q && (item_i.mode == MODE_BYTE);
  assign is_tick = armed_q && (item_i.mode == MODE_TICK);
  assign cnt_inc = cnt_q + 17'd1;
  assign ela_inc = (ela_q == TickMax) ? ela_q : ela_q + 16'd1;

  // next state and result for the item held in the input register
  always_comb begin
    armed_d     = armed_q;
    phase_d     = phase_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    id_d        = id_q;
    ela_d       = ela_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (is_arm) begin
      armed_d = 1'b1;
      phase_d = PH_SYNC1;
      len_d   = '0;
      cnt_d   = '0;
      id_d    = '0;
      ela_d   = '0;
    end else if (is_tick) begin
      ela_d = ela_inc;
      if (ela_inc >= timeout_ticks_i) begin
        armed_d          = 1'b0;
        res_valid_o      = 1'b1;
        res_o.status     = ST_TIMEOUT;
        res_o.message_id = '0;
      end
    end else if (is_byte) begin
      unique case (phase_q)
        PH_SYNC1: begin
          if (b == SyncFirst) phase_d = PH_SYNC2;
        end
        PH_SYNC2: begin
          phase_d = (b == SyncSecond) ? PH_LEN_HI : PH_SYNC1;
        end
        PH_LEN_HI: begin
          len_d   = {b, 8'h00};
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {len_q[15:8], len_q[7:0] | b};
          cnt_d   = '0;
          phase_d = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (cnt_q == '0) id_d = b;
          cnt_d = cnt_inc;
          // payload plus one checksum byte
          if (cnt_inc >= ({1'b0, len_q} + 17'd1)) phase_d = PH_END;
        end
        PH_END: begin
          if (b == EndByte) begin
            armed_d          = 1'b0;
            phase_d          = PH_SYNC1;
            res_valid_o      = 1'b1;
            res_o.status     = (id_q == AckId) ? ST_ACK : ST_NACK;
            res_o.message_id = id_q;
          end
        end
        default: phase_d = PH_SYNC1;
      endcase
    end
    if (!item_valid_i) res_valid_o = 1'b0;
  end

  // state registers, updated only when the held item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      phase_q <= PH_SYNC1;
      len_q   <= '0;
      cnt_q   <= '0;
      id_q    <= '0;
      ela_q   <= '0;
    end else if (item_valid_i && commit_i) begin
      armed_q <= armed_d;
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      id_q    <= id_d;
      ela_q   <= ela_d;
    end
  end

endmodule

[rtl/afr_out_reg.sv]
// result register on the output channel
// depends on afr_pkg
module afr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  afr_pkg::afr_out_t res_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output afr_pkg::afr_out_t out_item_o
);
  import afr_pkg::*;

  logic     valid_q;
  afr_out_t item_q;

  // a new result may enter when empty or when the held one leaves now
  assign room_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i && room_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i && room_o) item_q <= res_i;
  end

endmodule

[rtl/afr_checker.sv]
// port-level checks for the acknowledge frame receiver, bound to the top level
// depends on afr_pkg and ack_frame_receiver
module afr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input afr_pkg::afr_out_t out_item_o
);
  import afr_pkg::*;

  // a stalled result stays and does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // status is one of the three result codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == ST_ACK || out_item_o.status == ST_NACK ||
                     out_item_o.status == ST_TIMEOUT))
    else $error("bad status code");

  // a timeout carries no message id
  a_timeout_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_TIMEOUT |-> out_item_o.message_id == 8'h00)
    else $error("timeout with nonzero id");

  // acknowledge exactly when the reply id is the acknowledge id
  a_ack_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_TIMEOUT |->
      ((out_item_o.status == ST_ACK) == (out_item_o.message_id == AckId)))
    else $error("ack status does not match id");

  // input never stalls while the output side is free
  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind ack_frame_receiver afr_checker u_afr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

[verif/ack_frame_receiver_tb.sv]
// self-checking testbench for ack_frame_receiver: directed frames, timeouts, random traffic
// depends on afr_pkg and the ack_frame_receiver rtl; replies checked against an inline predictor
module ack_frame_receiver_tb;
  import afr_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned CycleLimit = 1000000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  afr_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  afr_out_t out_item;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [15:0] cfg_data = '0;

  // idling and stall rates, percent
  int send_idle_pct = 0;
  int stall_pct = 0;

  int unsigned cycle_count = 0;
  int mismatches = 0;
  int live_items = 0;

  // predictor state
  logic        armed = 1'b0;
  afr_phase_e  phase = PH_SYNC1;
  logic [15:0] frame_len = '0;
  logic [16:0] byte_cnt = '0;
  logic [7:0]  cap_id = '0;
  logic [15:0] elapsed = '0;
  logic [15:0] timeout_limit = TimeoutReset;

  afr_out_t pending_replies[$];

  ack_frame_receiver i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // random back-pressure on replies
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // predict the reply, if any, for one accepted request
  task automatic predict_reply(input afr_in_t req);
    afr_out_t rep;
    case (req.mode)
      MODE_ARM: begin
        armed = 1'b1;
        phase = PH_SYNC1;
        frame_len = '0;
        byte_cnt = '0;
        cap_id = '0;
        elapsed = '0;
      end
      MODE_TICK: if (armed) begin
        live_items++;
        if (elapsed != TickMax) elapsed = elapsed + 16'd1;
        if (elapsed >= timeout_limit) begin
          armed = 1'b0;
          rep.status = ST_TIMEOUT;
          rep.message_id = 8'h00;
          pending_replies.push_back(rep);
        end
      end
      MODE_BYTE: if (armed) begin
        live_items++;
        case (phase)
          PH_SYNC1: if (req.rx_byte == SyncFirst) phase = PH_SYNC2;
          PH_SYNC2: phase = (req.rx_byte == SyncSecond) ? PH_LEN_HI : PH_SYNC1;
          PH_LEN_HI: begin
            frame_len = {req.rx_byte, 8'h00};
            phase = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            frame_len = frame_len | {8'h00, req.rx_byte};
            byte_cnt = '0;
            phase = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (byte_cnt == '0) cap_id = req.rx_byte;
            byte_cnt = byte_cnt + 17'd1;
            if (byte_cnt >= {1'b0, frame_len} + 17'd1) phase = PH_END;
          end
          PH_END: if (req.rx_byte == EndByte) begin
            armed = 1'b0;
            phase = PH_SYNC1;
            rep.status = (cap_id == AckId) ? ST_ACK : ST_NACK;
            rep.message_id = cap_id;
            pending_replies.push_back(rep);
          end
          default: phase = PH_SYNC1;
        endcase
      end
      default: ;
    endcase
  endtask

  // check each delivered reply; sampled at the falling edge, taken at the next rising one
  always @(negedge clk) begin : check_replies
    afr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d, message_id 0x%02h",
               out_item.status, out_item.message_id);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatches++;
        end
        if (out_item.message_id !== want.message_id) begin
          $error("message_id: expected 0x%02h, got 0x%02h",
                 want.message_id, out_item.message_id);
          mismatches++;
        end
      end
    end
  end

  // send one request, with optional idle cycles ahead of it
  task automatic send_request(input logic [1:0] mode, input logic [7:0] data);
    afr_in_t req;
    req.mode = mode;
    req.rx_byte = data;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    predict_reply(req);
  endtask

  // one frame byte, sometimes preceded by a tick or an unused-mode request
  task automatic frame_byte(input logic [7:0] data);
    if ($urandom_range(9) == 0) send_request(MODE_TICK, 8'($urandom));
    if ($urandom_range(49) == 0) send_request(ModeUnused, 8'($urandom));
    send_request(MODE_BYTE, data);
  endtask

  // drain all replies and let the pipeline settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data <= ticks;
    @(negedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    timeout_limit = ticks;
  endtask

  // bytes and ticks before any arm are ignored
  task automatic test_disarmed();
    send_request(MODE_BYTE, SyncFirst);
    send_request(MODE_TICK, 8'hFF);
    send_request(ModeUnused, 8'h00);
  endtask

  // zero payload length: the checksum byte becomes the message id
  task automatic test_zero_length_ack();
    send_request(MODE_ARM, 8'h00);
    send_request(MODE_BYTE, SyncFirst);
    send_request(MODE_BYTE, SyncSecond);
    send_request(MODE_BYTE, 8'h00);
    send_request(MODE_BYTE, 8'h00);
    send_request(MODE_BYTE, AckId);
    send_request(MODE_BYTE, EndByte);
  endtask

  // re-arm mid frame, broken second sync, unused mode, a tick under the reset limit
  task automatic test_resync_nack();
    send_request(MODE_ARM, 8'h00);
    send_request(MODE_BYTE, SyncFirst);
    send_request(MODE_BYTE, SyncSecond);
    send_request(MODE_BYTE, 8'h00);
    send_request(MODE_ARM, 8'hFF);
    send_request(MODE_BYTE, SyncFirst);
    send_request(MODE_BYTE, 8'hA2);
    send_request(MODE_BYTE, SyncFirst);
    send_request(MODE_TICK, 8'h00);
    send_request(MODE_BYTE, SyncSecond);
    send_request(MODE_BYTE, 8'h00);
    send_request(MODE_BYTE, 8'h01);
    send_request(MODE_BYTE, 8'hFF);
    send_request(ModeUnused, 8'hFF);
    send_request(MODE_BYTE, 8'h11);
    send_request(MODE_BYTE, 8'h55);
    send_request(MODE_BYTE, EndByte);
  endtask

  // zero limit, then a limit lowered below the elapsed count while waiting
  task automatic test_timeout_limits();
    write_timeout(16'd0);
    send_request(MODE_ARM, 8'h00);
    send_request(MODE_TICK, 8'h00);
    write_timeout(16'd100);
    send_request(MODE_ARM, 8'h00);
    repeat (3) send_request(MODE_TICK, 8'h00);
    write_timeout(16'd2);
    send_request(MODE_TICK, 8'h00);
    write_timeout(16'd1);
    send_request(MODE_ARM, 8'h00);
    send_request(MODE_TICK, 8'h00);
  endtask

  // random exchanges: mostly well-formed frames, plus noise, broken syncs and timeouts
  task automatic test_random_traffic(input int n);
    int goal;
    int kind;
    int len;
    logic [7:0] data;
    goal = live_items + n;
    while (live_items < goal) begin
      kind = $urandom_range(9);
      if (kind != 0) send_request(MODE_ARM, 8'($urandom));
      repeat ($urandom_range(2)) frame_byte(8'($urandom));
      if (kind == 0) begin
        repeat ($urandom_range(1, 4)) frame_byte(8'($urandom));
      end else if (kind == 2 || kind == 3) begin
        // long length left unfinished, or a bare wait, then ticks: up to a timeout when the limit is at most 64
        if (kind == 2) begin
          frame_byte(SyncFirst);
          frame_byte(SyncSecond);
          frame_byte(8'($urandom_range(1, 255)));
          frame_byte(8'($urandom));
          repeat ($urandom_range(3)) frame_byte(8'($urandom));
        end
        if (timeout_limit <= 64) begin
          while (armed) send_request(MODE_TICK, 8'($urandom));
        end else begin
          repeat (3) send_request(MODE_TICK, 8'($urandom));
        end
      end else begin
        // broken second sync ahead of the frame
        if (kind == 1) begin
          frame_byte(SyncFirst);
          data = 8'($urandom);
          if (data == SyncSecond) data = SyncFirst;
          frame_byte(data);
        end
        frame_byte(SyncFirst);
        frame_byte(SyncSecond);
        len = ($urandom_range(14) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 5);
        frame_byte(8'(len >> 8));
        frame_byte(8'(len));
        frame_byte($urandom_range(1) ? AckId : 8'($urandom));
        repeat (len) frame_byte(8'($urandom));
        repeat ($urandom_range(2)) begin
          data = 8'($urandom);
          if (data == EndByte) data = ~data;
          frame_byte(data);
        end
        frame_byte(EndByte);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_disarmed();
    test_zero_length_ack();
    test_resync_nack();
    test_timeout_limits();

    // no idling, widest limit
    write_timeout(16'hFFFF);
    test_random_traffic(300);

    // sender mostly idle
    write_timeout(16'($urandom_range(4, 20)));
    send_idle_pct = 84;
    stall_pct = 0;
    test_random_traffic(300);

    // receiver mostly stalling
    write_timeout(16'($urandom_range(8, 40)));
    send_idle_pct = 0;
    stall_pct = 84;
    test_random_traffic(300);

    // light idling on both sides
    write_timeout(16'($urandom_range(3, 12)));
    send_idle_pct = 10;
    stall_pct = 10;
    test_random_traffic(300);

    wait_quiet();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/afr_pkg.sv
rtl/afr_parser.sv
rtl/afr_out_reg.sv
rtl/ack_frame_receiver.sv
rtl/afr_checker.sv
verif/ack_frame_receiver_tb.sv
